// ===== hw/rtl/slt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Static lease table package
// Sizes, entry type, operation and status codes, and controller states shared
// by the lease table cells and the top level.
// ----------------------------------------------------------------------------
package slt_pkg;

  // Table geometry.
  localparam int NUM_IFACES  = 16;
  localparam int TABLE_DEPTH = 64;
  localparam int AGE_W       = $clog2(TABLE_DEPTH);
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

  typedef logic [AGE_W-1:0]  age_t;
  typedef logic [FILL_W-1:0] fill_t;

  // One stored binding.
  typedef struct packed {
    logic [3:0]  port;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [31:0] life;
  } entry_t;

  // Operation codes of an input item.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISS    = 2'd1,
    STAT_UNBOUND = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/static_ipv4_lease_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Insert and refused items: result in the cycle after the start transfer; the
//   next item may start in that same result cycle (one item per cycle while
//   no lookup is busy). Lookup: busy while the cell ring rotates once past the
//   compare point, result in the cycle after; no new item is taken meanwhile.
// Results are strobed for one cycle by out_valid; the receiver cannot stall.
// Reset clears the fill count and bound mask; entries are not cleared.
// ----------------------------------------------------------------------------
// Static IPv4 lease table
// Per-interface MAC to IPv4 binding store built as a ring of cells. Inserts
// shift a new entry into the head cell; lookups rotate the ring once and keep
// the match from the newest valid entry.
// ----------------------------------------------------------------------------
module static_ipv4_lease_table_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic [3:0]  in_iface,
  input  wire logic [47:0] in_mac,
  input  wire logic [31:0] in_ipv4_addr,
  input  wire logic [31:0] in_lease_time,
  // Result channel
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_found_addr,
  output logic [31:0]      out_found_time,
  // Configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam int D = slt_pkg::TABLE_DEPTH;

  slt_pkg::state_t  state_r, state_nxt;
  slt_pkg::fill_t   fill_r, fill_nxt;
  slt_pkg::age_t    age_r, age_nxt;
  logic [15:0]      mask_r, mask_nxt;
  logic [3:0]       key_iface_r, key_iface_nxt;
  logic [47:0]      key_mac_r, key_mac_nxt;
  logic             hit_r, hit_nxt;
  logic [31:0]      hit_addr_r, hit_addr_nxt;
  logic [31:0]      hit_time_r, hit_time_nxt;
  logic             out_valid_r, out_valid_nxt;
  slt_pkg::status_t out_status_r, out_status_nxt;
  logic [31:0]      out_addr_r, out_addr_nxt;
  logic [31:0]      out_time_r, out_time_nxt;

  logic             accept;
  logic             iface_ok;
  logic             table_full;
  logic             ins_go;
  logic             lkp_go;
  logic             scan_en;
  logic             last_scan;
  logic             shift_en;
  logic             tap_valid;
  logic             tap_match;
  slt_pkg::entry_t  new_entry;
  slt_pkg::entry_t  cell_d [D];
  slt_pkg::entry_t  cell_q [D];

  // Command decode.
  assign accept     = start && !busy;
  assign iface_ok   = (int'(in_iface) < slt_pkg::NUM_IFACES) && mask_r[in_iface];
  assign table_full = (fill_r == slt_pkg::fill_t'(D));
  assign ins_go     = accept && (in_operation == slt_pkg::OP_INSERT) && iface_ok && !table_full;
  assign lkp_go     = accept && (in_operation == slt_pkg::OP_LOOKUP) && iface_ok;

  // Controller next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slt_pkg::ST_IDLE: if (lkp_go) state_nxt = slt_pkg::ST_SCAN;
      slt_pkg::ST_SCAN: if (age_r == '0) state_nxt = slt_pkg::ST_IDLE;
      default:          state_nxt = slt_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    busy      = 1'b0;
    scan_en   = 1'b0;
    last_scan = 1'b0;
    unique case (state_r)
      slt_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      slt_pkg::ST_SCAN: begin
        busy      = 1'b1;
        scan_en   = 1'b1;
        last_scan = (age_r == '0);
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Cell ring: inserts feed the head cell, a scan feeds the tail back round.
  assign shift_en  = ins_go || scan_en;
  assign new_entry = '{port: in_iface, mac: in_mac, ip: in_ipv4_addr, life: in_lease_time};

  for (genvar g = 0; g < D; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_d[g] = scan_en ? cell_q[D-1] : new_entry;
    end else begin : g_body
      assign cell_d[g] = cell_q[g-1];
    end
    slt_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (cell_d[g]),
      .q_out    (cell_q[g])
    );
  end

  // The tail cell is the compare point; entries pass it oldest first, so a
  // later match overrides an earlier one.
  assign tap_valid = (slt_pkg::fill_t'(age_r) < fill_r);
  assign tap_match = scan_en && tap_valid && (cell_q[D-1].port == key_iface_r) &&
                     (cell_q[D-1].mac == key_mac_r);

  // Lookup key, scan position and best match so far.
  always_comb begin
    key_iface_nxt = key_iface_r;
    key_mac_nxt   = key_mac_r;
    age_nxt       = age_r;
    hit_nxt       = hit_r;
    hit_addr_nxt  = hit_addr_r;
    hit_time_nxt  = hit_time_r;
    if (lkp_go) begin
      key_iface_nxt = in_iface;
      key_mac_nxt   = in_mac;
      age_nxt       = slt_pkg::age_t'(D - 1);
      hit_nxt       = 1'b0;
    end else if (scan_en) begin
      age_nxt = age_r - 1'b1;
      if (tap_match) begin
        hit_nxt      = 1'b1;
        hit_addr_nxt = cell_q[D-1].ip;
        hit_time_nxt = cell_q[D-1].life;
      end
    end
  end

  // Fill count and bound mask.
  always_comb begin
    fill_nxt = ins_go ? fill_r + 1'b1 : fill_r;
    mask_nxt = cfg_we ? cfg_wdata : mask_r;
  end

  // Result register: lookup results at the end of a scan, others at once.
  always_comb begin
    out_valid_nxt  = (accept && !lkp_go) || last_scan;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_time_nxt   = out_time_r;
    priority if (last_scan) begin
      if (tap_match) begin
        out_status_nxt = slt_pkg::STAT_OK;
        out_addr_nxt   = cell_q[D-1].ip;
        out_time_nxt   = cell_q[D-1].life;
      end else if (hit_r) begin
        out_status_nxt = slt_pkg::STAT_OK;
        out_addr_nxt   = hit_addr_r;
        out_time_nxt   = hit_time_r;
      end else begin
        out_status_nxt = slt_pkg::STAT_MISS;
        out_addr_nxt   = '0;
        out_time_nxt   = '0;
      end
    end else if (accept && !lkp_go) begin
      out_addr_nxt = '0;
      out_time_nxt = '0;
      if (!iface_ok) begin
        out_status_nxt = slt_pkg::STAT_UNBOUND;
      end else if (table_full) begin
        out_status_nxt = slt_pkg::STAT_FULL;
      end else begin
        out_status_nxt = slt_pkg::STAT_OK;
      end
    end else begin
      out_status_nxt = out_status_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slt_pkg::ST_IDLE;
      fill_r      <= '0;
      age_r       <= '0;
      mask_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      age_r       <= age_nxt;
      mask_r      <= mask_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_iface_r  <= key_iface_nxt;
    key_mac_r    <= key_mac_nxt;
    hit_addr_r   <= hit_addr_nxt;
    hit_time_r   <= hit_time_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_time_r   <= out_time_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found_addr = out_addr_r;
  assign out_found_time = out_time_r;

  // No result transfer is strobed while a lookup is still rotating the ring.
  a_no_result_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobed during a scan");

  // The fill count never passes the table depth.
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= slt_pkg::fill_t'(D))
    else $error("fill count beyond table depth");

  // The last scan step ends the lookup with exactly one result.
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    last_scan |=> (out_valid && !busy))
    else $error("lookup did not end with a result");

  // A stored insert grows the table by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_go |=> (fill_r == slt_pkg::fill_t'($past(fill_r) + 1'b1)))
    else $error("insert did not advance the fill count");

endmodule
`default_nettype wire

// ===== hw/rtl/slt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lease table cell
// Holds one binding and takes its neighbour's binding whenever the chain
// shifts, either to make room for an insert or to rotate during a lookup.
// ----------------------------------------------------------------------------
module slt_cell (
  input  wire logic            clk,
  input  wire logic            shift_en,
  input  wire slt_pkg::entry_t d_in,
  output slt_pkg::entry_t      q_out
);

  slt_pkg::entry_t entry_r;
  slt_pkg::entry_t entry_nxt;

  // Take the neighbour's entry on a shift, otherwise hold.
  always_comb begin
    entry_nxt = shift_en ? d_in : entry_r;
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q_out = entry_r;

endmodule
`default_nettype wire
